// File: design/hwlfir_pkg.sv
// Package with widths, types and the fixed coefficient table of the lowpass FIR.
package hwlfir_pkg;

    localparam int TAPS        = 51;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;
    localparam int TAP_BITS    = $clog2(TAPS + 1);
    // A product plus enough guard bits for the sum over all taps.
    localparam int ACC_BITS    = SAMPLE_BITS + COEF_BITS + TAP_BITS;
    localparam int ROUND_SHIFT = COEF_BITS - 1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic signed [ACC_BITS-1:0]    acc_t;

    // Controls for each cell in the chain.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    // Windowed-sinc lowpass taps in Q1.15.
    localparam coef_t COEFS [TAPS] = '{
        16'sd0,     16'sd21,    16'sd41,    16'sd51,    16'sd40,
        16'sd0,     -16'sd66,   -16'sd136,  -16'sd171,  -16'sd132,
        16'sd0,     16'sd199,   16'sd390,   16'sd470,   16'sd349,
        16'sd0,     -16'sd501,  -16'sd975,  -16'sd1181, -16'sd894,
        16'sd0,     16'sd1445,  16'sd3200,  16'sd4888,  16'sd6109,
        16'sd6554,  16'sd6109,  16'sd4888,  16'sd3200,  16'sd1445,
        16'sd0,     -16'sd894,  -16'sd1181, -16'sd975,  -16'sd501,
        16'sd0,     16'sd349,   16'sd470,   16'sd390,   16'sd199,
        16'sd0,     -16'sd132,  -16'sd171,  -16'sd136,  16'sd0,
        16'sd40,    16'sd51,    16'sd41,    16'sd21,    16'sd0,
        16'sd0
    };

endpackage

// File: design/hwlfir_if.sv
// Stream interfaces for the input samples and the filtered samples.
interface hwlfir_in_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [hwlfir_pkg::SAMPLE_BITS-1:0] sample_in;
    logic                                      last_in;

    modport source (output valid, output sample_in, output last_in, input ready);
    modport sink   (input valid, input sample_in, input last_in, output ready);
endinterface

interface hwlfir_out_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [hwlfir_pkg::SAMPLE_BITS-1:0] sample_out;
    logic                                      last_out;

    modport source (output valid, output sample_out, output last_out, input ready);
    modport sink   (input valid, input sample_out, input last_out, output ready);
endinterface

// File: design/hamming_windowed_lowpass_fir.sv
// Top level of the 51-tap Hamming-windowed lowpass FIR built as a chain of tap cells.
// A result is offered in the cycle after its input transfer.
// Throughput: one sample per cycle; each tap cell holds one partial sum, so the
// chain takes a new sample whenever the output register is empty or being read.
// A result not taken holds the output register and stalls the input side.
// Reset clears all partial sums (history reads as zero) and the output valid flag.
module hamming_windowed_lowpass_fir (
    input  logic           clk,
    input  logic           rst_n,
    hwlfir_in_if.sink      raw,
    hwlfir_out_if.source   filtered
);
    import hwlfir_pkg::*;

    localparam int SHIFTED_BITS = ACC_BITS - ROUND_SHIFT;
    localparam logic signed [SHIFTED_BITS-1:0] SAT_HI =
        SHIFTED_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SHIFTED_BITS-1:0] SAT_LO =
        SHIFTED_BITS'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    acc_t                           sums [TAPS];
    cell_ctrl_t                     head_ctrl;
    cell_ctrl_t                     tail_ctrl;
    logic                           xfer_in;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           last_reg;
    acc_t                           rounded;
    logic signed [SHIFTED_BITS-1:0] shifted;

    // Input transfer and backpressure from the output register.
    assign raw.ready = !out_valid_reg || filtered.ready;
    assign xfer_in   = raw.valid && raw.ready;

    // The head cell keeps the finished sum; the others are flushed after a last sample.
    assign head_ctrl.shift = xfer_in;
    assign head_ctrl.clear = 1'b0;
    assign tail_ctrl.shift = xfer_in;
    assign tail_ctrl.clear = raw.last_in;

    // Chain of tap cells; each takes the partial sum of the cell after it.
    for (genvar k = 0; k < TAPS; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            hwlfir_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctrl   (head_ctrl),
                .x      (raw.sample_in),
                .coef   (COEFS[k]),
                .sum_in (sums[k+1]),
                .sum    (sums[k])
            );
        end
        else if (k == TAPS - 1)
        begin : g_end
            hwlfir_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctrl   (tail_ctrl),
                .x      (raw.sample_in),
                .coef   (COEFS[k]),
                .sum_in ('0),
                .sum    (sums[k])
            );
        end
        else
        begin : g_mid
            hwlfir_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctrl   (tail_ctrl),
                .x      (raw.sample_in),
                .coef   (COEFS[k]),
                .sum_in (sums[k+1]),
                .sum    (sums[k])
            );
        end
    end

    // Output valid flag follows transfers on both sides.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (xfer_in)
        begin
            out_valid_next = 1'b1;
        end
        else if (filtered.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // The end-of-stream flag travels alongside the head sum.
    always_ff @(posedge clk)
    begin
        if (xfer_in)
        begin
            last_reg <= raw.last_in;
        end
    end

    // Round half up, dropping the 15 fraction bits of the Q1.15 taps, and saturate.
    always_comb
    begin
        rounded = sums[0] + (ACC_BITS'(1) <<< (ROUND_SHIFT - 1));
        shifted = SHIFTED_BITS'(rounded >>> ROUND_SHIFT);
        if (shifted > SAT_HI)
        begin
            filtered.sample_out = SAT_HI[SAMPLE_BITS-1:0];
        end
        else if (shifted < SAT_LO)
        begin
            filtered.sample_out = SAT_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            filtered.sample_out = shifted[SAMPLE_BITS-1:0];
        end
    end

    assign filtered.valid    = out_valid_reg;
    assign filtered.last_out = last_reg;

`ifndef SYNTH
    // Every input transfer yields a result in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        xfer_in |=> filtered.valid)
        else $error("no result after input transfer");

    // After a last sample the history in the chain is gone.
    a_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer_in && raw.last_in) |=> (sums[1] == '0 && sums[TAPS-1] == '0))
        else $error("history not cleared after end of stream");

    // A stalled result keeps its sum.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (filtered.valid && !filtered.ready) |=> $stable(sums[0]))
        else $error("held result changed");

    // The output register empties only through an output transfer.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(filtered.ready))
        else $error("result dropped without transfer");
`endif

endmodule

// File: design/hwlfir_cell.sv
// One cell of the transposed-form FIR chain: a multiply and a partial-sum register.
module hwlfir_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  hwlfir_pkg::cell_ctrl_t ctrl,
    input  hwlfir_pkg::sample_t    x,
    input  hwlfir_pkg::coef_t      coef,
    input  hwlfir_pkg::acc_t       sum_in,
    output hwlfir_pkg::acc_t       sum
);
    import hwlfir_pkg::*;

    logic signed [SAMPLE_BITS+COEF_BITS-1:0] prod;
    acc_t                                    sum_reg;
    acc_t                                    sum_next;

    // The product of this tap is added to the partial sum handed over by the neighbor.
    always_comb
    begin
        prod = x * coef;
        if (ctrl.clear)
        begin
            sum_next = '0;
        end
        else
        begin
            sum_next = sum_in + ACC_BITS'(prod);
        end
    end

    // Partial-sum register, updated only on an input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

// File: test/testbench.sv
// Self-checking testbench for the 51-tap Hamming-windowed lowpass FIR.
`timescale 1ns / 100ps

module testbench;
    import hwlfir_pkg::*;

    localparam int FIR_LEN      = 51;
    localparam int HIST_LEN     = FIR_LEN - 1;
    localparam int RANDOM_ITEMS = 750;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AFTER   = 60;
    localparam int MAX_REPORTS  = 100;

    // Idling profile that applies while a sample is being sent.
    typedef enum logic [1:0] {
        PH_RX_SLOW,
        PH_TX_SLOW,
        PH_NO_IDLE
    } idle_phase_t;

    typedef struct {
        sample_t     sample;
        logic        last;
        idle_phase_t phase;
        bit          drain_first;
    } stimulus_t;

    typedef struct {
        sample_t sample;
        logic    last;
    } filtered_t;

    logic clk = 1'b0;
    logic rst_n;

    hwlfir_in_if  raw_if ();
    hwlfir_out_if filt_if ();

    hamming_windowed_lowpass_fir dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .raw      (raw_if),
        .filtered (filt_if)
    );

    // Lowpass taps in Q1.15.
    int fir_coefs [0:FIR_LEN-1] = '{
           0,    21,    41,    51,    40,     0,   -66,  -136,  -171,  -132,
           0,   199,   390,   470,   349,     0,  -501,  -975, -1181,  -894,
           0,  1445,  3200,  4888,  6109,  6554,  6109,  4888,  3200,  1445,
           0,  -894, -1181,  -975,  -501,     0,   349,   470,   390,   199,
           0,  -132,  -171,  -136,     0,    40,    51,    41,    21,     0,
           0
    };

    sample_t     history [0:HIST_LEN-1];
    stimulus_t   pending_samples[$];
    filtered_t   expected_outputs[$];
    idle_phase_t idle_phase = PH_RX_SLOW;
    int          results_seen = 0;
    int          error_count = 0;
    int          hold_left = 0;
    bit          long_hold_done = 1'b0;

    function automatic int unsigned sender_gap_pct(idle_phase_t p);
        case (p)
            PH_RX_SLOW: return 8;
            PH_TX_SLOW: return 84;
            default:    return 0;
        endcase
    endfunction

    function automatic int unsigned receiver_stall_pct(idle_phase_t p);
        case (p)
            PH_RX_SLOW: return 84;
            PH_TX_SLOW: return 8;
            default:    return 0;
        endcase
    endfunction

    // One filter step: convolve, round half up dropping the 15 fraction bits of the Q1.15
    // taps, saturate, then update the history (cleared after the end of a stream).
    function automatic filtered_t lowpass_step(sample_t x, logic last);
        longint    acc;
        longint    y;
        filtered_t r;
        acc = longint'(fir_coefs[0]) * longint'(x);
        for (int n = 1; n < FIR_LEN; n++)
            acc += longint'(fir_coefs[n]) * longint'(history[n-1]);
        y = (acc + 64'sd16384) >>> 15;
        if (y > 32767)
            y = 32767;
        if (y < -32768)
            y = -32768;
        r.sample = sample_t'(y);
        r.last   = last;
        if (last)
        begin
            foreach (history[i])
                history[i] = '0;
        end
        else
        begin
            for (int i = HIST_LEN - 1; i > 0; i--)
                history[i] = history[i-1];
            history[0] = x;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS)
            $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic queue_sample(input sample_t s, input logic last, input idle_phase_t p,
                                input bit drain);
        stimulus_t item;
        item.sample      = s;
        item.last        = last;
        item.phase       = p;
        item.drain_first = drain;
        pending_samples.push_back(item);
    endtask

    // Clock generation.
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

    // Sender: offers queued samples and predicts the result of each transfer.
    always @(posedge clk or negedge rst_n)
    begin : sender
        stimulus_t nxt;
        filtered_t pred;
        bit        offer;
        if (!rst_n)
        begin
            raw_if.valid     <= 1'b0;
            raw_if.sample_in <= '0;
            raw_if.last_in   <= 1'b0;
        end
        else
        begin
            if (raw_if.valid && raw_if.ready)
            begin
                pred = lowpass_step(raw_if.sample_in, raw_if.last_in);
                expected_outputs.push_back(pred);
            end
            if (!raw_if.valid || raw_if.ready)
            begin
                offer = 1'b0;
                if (pending_samples.size() != 0)
                begin
                    if (pending_samples[0].drain_first)
                        offer = (expected_outputs.size() == 0);
                    else
                        offer = ($urandom_range(99) >= sender_gap_pct(pending_samples[0].phase));
                end
                if (offer)
                begin
                    nxt = pending_samples.pop_front();
                    raw_if.valid     <= 1'b1;
                    raw_if.sample_in <= nxt.sample;
                    raw_if.last_in   <= nxt.last;
                    idle_phase       <= nxt.phase;
                end
                else
                begin
                    // Idle cycles carry junk that the block must ignore.
                    raw_if.valid     <= 1'b0;
                    raw_if.sample_in <= sample_t'($urandom);
                    raw_if.last_in   <= 1'($urandom_range(1));
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off that backs up the input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_if.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            filt_if.ready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (!long_hold_done && results_seen >= HOLD_AFTER)
        begin
            filt_if.ready  <= 1'b0;
            hold_left      <= LONG_HOLD;
            long_hold_done <= 1'b1;
        end
        else
        begin
            filt_if.ready <= ($urandom_range(99) >= receiver_stall_pct(idle_phase));
        end
    end

    // Monitor: checks every output transfer against the oldest prediction.
    always @(posedge clk)
    begin : monitor
        filtered_t want;
        if (rst_n && filt_if.valid && filt_if.ready)
        begin
            if (expected_outputs.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result sample %0d last %0b",
                                          filt_if.sample_out, filt_if.last_out));
            end
            else
            begin
                want = expected_outputs.pop_front();
                if (filt_if.sample_out !== want.sample)
                    report_mismatch($sformatf("result %0d: sample_out %0d, expected %0d",
                                              results_seen, filt_if.sample_out,
                                              want.sample));
                if (filt_if.last_out !== want.last)
                    report_mismatch($sformatf("result %0d: last_out %0b, expected %0b",
                                              results_seen, filt_if.last_out, want.last));
            end
            results_seen <= results_seen + 1;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int          made;
        int          kind;
        int          len;
        int          c;
        bit          ends_last;
        bit          flip;
        sample_t     s;
        logic        l;
        idle_phase_t p;

        raw_if.valid     = 1'b0;
        raw_if.sample_in = '0;
        raw_if.last_in   = 1'b0;
        filt_if.ready    = 1'b0;
        rst_n            = 1'b0;
        foreach (history[i])
            history[i] = '0;

        // Directed: first sample ends a stream, full-scale extremes, impulses
        // of one half that land on odd taps (exact rounding halves), back-to-back
        // stream ends and alternating bit patterns.
        queue_sample(16'sd32767, 1'b1, PH_RX_SLOW, 1'b0);
        queue_sample(-16'sd32768, 1'b0, PH_RX_SLOW, 1'b0);
        queue_sample(16'sd16384, 1'b0, PH_RX_SLOW, 1'b0);
        repeat (4)
            queue_sample(16'sd0, 1'b0, PH_RX_SLOW, 1'b0);
        queue_sample(16'sd0, 1'b1, PH_RX_SLOW, 1'b0);
        queue_sample(-16'sd16384, 1'b0, PH_RX_SLOW, 1'b0);
        repeat (3)
            queue_sample(16'sd0, 1'b0, PH_RX_SLOW, 1'b0);
        queue_sample(16'sd0, 1'b1, PH_RX_SLOW, 1'b0);
        queue_sample(16'sd1, 1'b1, PH_RX_SLOW, 1'b0);
        queue_sample(16'sd1, 1'b0, PH_RX_SLOW, 1'b0);
        queue_sample(-16'sd1, 1'b0, PH_RX_SLOW, 1'b0);
        queue_sample(16'sh5555, 1'b0, PH_RX_SLOW, 1'b0);
        queue_sample(16'shAAAA, 1'b0, PH_RX_SLOW, 1'b0);
        queue_sample(16'sh00FF, 1'b0, PH_RX_SLOW, 1'b0);
        queue_sample(16'sd32767, 1'b1, PH_RX_SLOW, 1'b0);

        // Random streams of several kinds, most ending with a stream end.
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            kind      = $urandom_range(4);
            ends_last = ($urandom_range(3) != 0);
            flip      = 1'($urandom_range(1));
            case (kind)
                0:       len = $urandom_range(40, 5);
                1:       len = $urandom_range(80, 20);
                2:       len = $urandom_range(70, 55);
                3:       len = FIR_LEN;
                default: len = $urandom_range(100, 30);
            endcase
            // The final stream is cut short so the total stays on target.
            if (len > RANDOM_ITEMS - made)
                len = RANDOM_ITEMS - made;
            for (int k = 0; k < len; k++)
            begin
                l = ends_last && (k == len - 1);
                case (kind)
                    0:
                    begin
                        // Noise with stray stream ends.
                        s = sample_t'($urandom);
                        l = ($urandom_range(7) == 0);
                    end
                    1:
                        s = sample_t'(int'($urandom_range(1023)) - 512);
                    2:
                        s = flip ? -16'sd32768 : 16'sd32767;
                    3:
                    begin
                        // Signs follow the taps so the last output saturates.
                        c = fir_coefs[FIR_LEN - 1 - k];
                        if (c == 0)
                            s = sample_t'($urandom);
                        else if ((c > 0) != flip)
                            s = 16'sd32767;
                        else
                            s = -16'sd32768;
                    end
                    default:
                        s = sample_t'($urandom);
                endcase
                if (made < RANDOM_ITEMS / 3)
                    p = PH_RX_SLOW;
                else if (made < 2 * RANDOM_ITEMS / 3)
                    p = PH_TX_SLOW;
                else
                    p = PH_NO_IDLE;
                queue_sample(s, l, p,
                             (made == RANDOM_ITEMS / 3) || (made == 2 * RANDOM_ITEMS / 3));
                made++;
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_samples.size() != 0 || raw_if.valid || expected_outputs.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (expected_outputs.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_outputs.size()));

        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
